>>> rtl/stc_pkg.sv
// stc_pkg: widths, stage numbering, pipeline item type and the per-stage
// datapath function of the sphere/triangle contact pipeline.
// Depends on nothing; used by stc_stage and sphere_triangle_contact.
package stc_pkg;

  localparam int CW      = 20;              // coordinate component width
  localparam int NF      = CW - 2;          // normal fraction bits
  localparam int TF      = 18;              // edge parameter fraction bits
  localparam int LX      = 8;               // extra length fraction bits
  localparam int RW      = 20;              // radius / depth width
  localparam int FIELD_W = 3 * CW;

  localparam int IN_W    = 5 * FIELD_W + RW;              // 320
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = 1 + FIELD_W + RW;              // 81
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  localparam int EW      = CW + 1;
  localparam int PDW     = 2 * EW;
  localparam int DOTW    = PDW + 2;
  localparam int DW      = CW + 2;
  localparam int NDW     = CW + DW;
  localparam int RRW     = DW + 2;
  localparam int PW      = RRW + 1;
  localparam int UW      = PW + 1;
  localparam int UEW     = UW + EW;
  localparam int CRW     = UEW + 1;
  localparam int CNW     = CRW + CW;
  localparam int TOTW    = CNW + 2;
  localparam int ATW     = EW + TF + 1;
  localparam int VW      = CW + 4;
  localparam int SQVW    = 2 * VW;
  localparam int DSQW    = SQVW + 2;
  localparam int NVW     = VW + 1;
  localparam int SQW     = 2 * NVW;
  localparam int SUMW    = SQW + 2;
  localparam int XW      = 60;
  localparam int LW      = XW / 2;
  localparam int SRW     = LW + 2;
  localparam int QW      = CW;
  localparam int NW      = NVW + NF + LX + 1;

  localparam logic [QW-1:0] QMAX = QW'((1 << (CW - 1)) - 1);

  // stage numbering
  localparam int ST_DIFF   = 0;
  localparam int ST_MUL1   = 1;
  localparam int ST_SUM1   = 2;
  localparam int ST_MUL2   = 3;
  localparam int ST_RND    = 4;
  localparam int ST_SUB2   = 5;
  localparam int ST_MUL3   = 6;
  localparam int ST_CROSS  = 7;
  localparam int ST_MUL4   = 8;
  localparam int ST_TRI    = 9;
  localparam int ST_EPT    = 10;
  localparam int ST_MUL5   = 11;
  localparam int ST_DSQ    = 12;
  localparam int ST_SEL    = 13;
  localparam int ST_SUM2   = 14;
  localparam int ED_STEPS  = 3;
  localparam int ED_STAGES = TF / ED_STEPS;
  localparam int ST_ED0    = ST_MUL2;
  localparam int SQ_STEPS  = 3;
  localparam int SQ_STAGES = LW / SQ_STEPS;
  localparam int ST_SQ0    = ST_SUM2 + 1;
  localparam int ST_PREP   = ST_SQ0 + SQ_STAGES;
  localparam int QD_STEPS  = 4;
  localparam int QD_STAGES = QW / QD_STEPS;
  localparam int ST_QD0    = ST_PREP + 1;
  localparam int ST_PACK   = ST_QD0 + QD_STAGES;
  localparam int N_STAGES  = ST_PACK + 1;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct {
    crd_t                   vtx [3][3];
    crd_t                   n [3];
    crd_t                   ctr [3];
    logic [RW-1:0]          rad;
    logic signed [EW-1:0]   e [3][3];
    logic signed [EW-1:0]   ap [3][3];
    logic signed [PDW-1:0]  pdist [3];
    logic signed [PDW-1:0]  pn [3][3];
    logic signed [PDW-1:0]  pd [3][3];
    logic signed [DOTW-1:0] plane_d;
    logic signed [DOTW-1:0] num [3];
    logic signed [DOTW-1:0] den [3];
    logic                   miss;
    logic signed [DW-1:0]   d;
    logic                   cla [3];
    logic                   clb [3];
    logic [DOTW-1:0]        drem [3];
    logic [TF-1:0]          tq [3];
    logic signed [NDW-1:0]  nd [3];
    logic signed [RRW-1:0]  r [3];
    logic signed [PW-1:0]   p0 [3];
    logic signed [UW-1:0]   u [3][3];
    logic signed [UEW-1:0]  ue [3][6];
    logic signed [CRW-1:0]  cr [3][3];
    logic signed [CNW-1:0]  cn [3][3];
    logic                   in_tri;
    logic signed [ATW-1:0]  at [3][3];
    logic signed [VW-1:0]   vv [3][3];
    logic [SQVW-1:0]        sq [3][3];
    logic [DSQW-1:0]        dsq [3];
    logic                   ok;
    logic signed [NVW-1:0]  nv [3];
    logic [SQW-1:0]         nsq [3];
    logic [XW-1:0]          x;
    logic [SRW-1:0]         srem;
    logic [LW-1:0]          root;
    logic [RW-1:0]          depth;
    logic [NVW-1:0]         mag [3];
    logic                   neg [3];
    logic [NW-1:0]          qrem [3];
    logic [QW-1:0]          q [3];
    logic                   hit;
    logic [FIELD_W-1:0]     pnorm;
  } item_t;

  function automatic item_t stc_step(input item_t a, input int idx);
    item_t                  o;
    logic signed [DOTW-1:0] lim;
    logic signed [DOTW-1:0] tr44;
    logic signed [NDW-1:0]  tn;
    logic signed [TOTW-1:0] tot;
    logic signed [TF:0]     tqs;
    logic signed [ATW-1:0]  ta;
    logic signed [VW-1:0]   ep;
    logic [2*RW-1:0]        rr;
    logic [DOTW:0]          dt;
    logic [SRW+1:0]         st;
    logic [SRW+1:0]         trl;
    logic signed [LW+1:0]   dep;
    logic [LW:0]            rl;
    logic [NW-1:0]          dv;
    logic [QW-1:0]          qq;
    logic                   qb;
    logic [SUMW-1:0]        sum;
    int                     nx;
    int                     bi;
    int                     j;
    int                     kk;
    o = a;
    case (idx)
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          nx = (k == 2) ? 0 : k + 1;
          for (int i = 0; i < 3; i++) begin
            o.e[k][i]  = EW'(a.vtx[nx][i]) - EW'(a.vtx[k][i]);
            o.ap[k][i] = EW'(a.ctr[i]) - EW'(a.vtx[k][i]);
          end
        end
      end
      ST_MUL1: begin
        for (int i = 0; i < 3; i++) begin
          o.pdist[i] = PDW'(a.ap[0][i]) * PDW'(a.n[i]);
          for (int k = 0; k < 3; k++) begin
            o.pn[k][i] = PDW'(a.ap[k][i]) * PDW'(a.e[k][i]);
            o.pd[k][i] = PDW'(a.e[k][i]) * PDW'(a.e[k][i]);
          end
        end
      end
      ST_SUM1: begin
        o.plane_d = DOTW'(a.pdist[0]) + DOTW'(a.pdist[1]) + DOTW'(a.pdist[2]);
        lim = DOTW'(a.rad);
        lim = lim <<< NF;
        o.miss = (o.plane_d < -lim) || (o.plane_d > lim);
        tr44 = DOTW'(1);
        tr44 = o.plane_d + (tr44 <<< (NF - 1));
        o.d = DW'(tr44 >>> NF);
        for (int k = 0; k < 3; k++) begin
          o.num[k] = DOTW'(a.pn[k][0]) + DOTW'(a.pn[k][1]) + DOTW'(a.pn[k][2]);
          o.den[k] = DOTW'(a.pd[k][0]) + DOTW'(a.pd[k][1]) + DOTW'(a.pd[k][2]);
          o.cla[k] = (o.den[k] <= 0) || (o.num[k] <= 0);
          o.clb[k] = o.num[k] >= o.den[k];
          o.drem[k] = o.num[k];
          o.tq[k] = '0;
        end
      end
      ST_MUL2: begin
        for (int i = 0; i < 3; i++) o.nd[i] = NDW'(a.n[i]) * NDW'(a.d);
      end
      ST_RND: begin
        for (int i = 0; i < 3; i++) begin
          tn = NDW'(1);
          tn = a.nd[i] + (tn <<< (NF - 1));
          o.r[i] = RRW'(tn >>> NF);
          o.p0[i] = PW'(a.ctr[i]) - PW'(o.r[i]);
        end
      end
      ST_SUB2: begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) o.u[k][i] = UW'(a.p0[i]) - UW'(a.vtx[k][i]);
      end
      ST_MUL3: begin
        for (int k = 0; k < 3; k++) begin
          o.ue[k][0] = UEW'(a.u[k][1]) * UEW'(a.e[k][2]);
          o.ue[k][1] = UEW'(a.u[k][2]) * UEW'(a.e[k][1]);
          o.ue[k][2] = UEW'(a.u[k][2]) * UEW'(a.e[k][0]);
          o.ue[k][3] = UEW'(a.u[k][0]) * UEW'(a.e[k][2]);
          o.ue[k][4] = UEW'(a.u[k][0]) * UEW'(a.e[k][1]);
          o.ue[k][5] = UEW'(a.u[k][1]) * UEW'(a.e[k][0]);
        end
      end
      ST_CROSS: begin
        for (int k = 0; k < 3; k++) begin
          o.cr[k][0] = CRW'(a.ue[k][0]) - CRW'(a.ue[k][1]);
          o.cr[k][1] = CRW'(a.ue[k][2]) - CRW'(a.ue[k][3]);
          o.cr[k][2] = CRW'(a.ue[k][4]) - CRW'(a.ue[k][5]);
        end
      end
      ST_MUL4: begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) o.cn[k][i] = CNW'(a.cr[k][i]) * CNW'(a.n[i]);
      end
      ST_TRI: begin
        o.in_tri = 1'b1;
        for (int k = 0; k < 3; k++) begin
          tot = TOTW'(a.cn[k][0]) + TOTW'(a.cn[k][1]) + TOTW'(a.cn[k][2]);
          if (tot > 0) o.in_tri = 1'b0;
          tqs = {1'b0, a.tq[k]};
          for (int i = 0; i < 3; i++) o.at[k][i] = ATW'(a.e[k][i]) * ATW'(tqs);
        end
      end
      ST_EPT: begin
        for (int k = 0; k < 3; k++) begin
          nx = (k == 2) ? 0 : k + 1;
          for (int i = 0; i < 3; i++) begin
            ta = ATW'(1);
            ta = a.at[k][i] + (ta <<< (TF - 1));
            ep = VW'(ta >>> TF) + VW'(a.vtx[k][i]);
            if (a.cla[k]) ep = VW'(a.vtx[k][i]);
            else if (a.clb[k]) ep = VW'(a.vtx[nx][i]);
            o.vv[k][i] = VW'(a.ctr[i]) - ep;
          end
        end
      end
      ST_MUL5: begin
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) o.sq[k][i] = SQVW'(a.vv[k][i]) * SQVW'(a.vv[k][i]);
      end
      ST_DSQ: begin
        rr = (2*RW)'(a.rad) * (2*RW)'(a.rad);
        qb = 1'b0;
        for (int k = 0; k < 3; k++) begin
          o.dsq[k] = DSQW'(a.sq[k][0]) + DSQW'(a.sq[k][1]) + DSQW'(a.sq[k][2]);
          if (o.dsq[k] < DSQW'(rr)) qb = 1'b1;
        end
        o.ok = !a.miss && (a.in_tri || qb);
      end
      ST_SEL: begin
        bi = 0;
        if (a.dsq[1] < a.dsq[0]) bi = 1;
        if (a.dsq[2] < a.dsq[bi]) bi = 2;
        for (int i = 0; i < 3; i++) begin
          o.nv[i] = a.in_tri ? NVW'(a.r[i]) : NVW'(a.vv[bi][i]);
          o.nsq[i] = SQW'(o.nv[i]) * SQW'(o.nv[i]);
        end
      end
      ST_SUM2: begin
        sum = SUMW'(a.nsq[0]) + SUMW'(a.nsq[1]) + SUMW'(a.nsq[2]);
        o.x = {sum[XW-2*LX-1:0], (2*LX)'(0)};
        o.srem = '0;
        o.root = '0;
      end
      ST_PREP: begin
        rl = (LW+1)'(a.root) + (LW+1)'(1 << (LX - 1));
        dep = (LW+2)'(a.rad) - (LW+2)'(rl >> LX);
        o.depth = dep[LW+1] ? '0 : RW'(dep);
        for (int i = 0; i < 3; i++) begin
          o.neg[i] = a.nv[i][NVW-1];
          o.mag[i] = o.neg[i] ? NVW'(-a.nv[i]) : NVW'(a.nv[i]);
          o.qrem[i] = (NW'(o.mag[i]) << (NF + LX)) + NW'(a.root >> 1);
          o.q[i] = '0;
        end
      end
      ST_PACK: begin
        o.hit = a.ok;
        o.pnorm = '0;
        for (int i = 0; i < 3; i++) begin
          qq = (a.q[i] > QMAX) ? QMAX : a.q[i];
          if (a.neg[i]) qq = -qq;
          o.pnorm[i*CW +: CW] = qq;
        end
        if (a.root == '0 || !a.ok) o.pnorm = '0;
        if (!a.ok) o.depth = '0;
      end
      default: ;
    endcase

    // edge parameter division, shift-subtract
    if (idx >= ST_ED0 && idx < ST_ED0 + ED_STAGES) begin
      for (int s = 0; s < ED_STEPS; s++) begin
        for (int k = 0; k < 3; k++) begin
          dt = {o.drem[k], 1'b0};
          qb = dt >= {1'b0, o.den[k]};
          if (qb) dt = dt - {1'b0, o.den[k]};
          o.drem[k] = dt[DOTW-1:0];
          o.tq[k] = {o.tq[k][TF-2:0], qb};
        end
      end
    end

    // square root, two radicand bits a step
    if (idx >= ST_SQ0 && idx < ST_SQ0 + SQ_STAGES) begin
      for (int s = 0; s < SQ_STEPS; s++) begin
        j = LW - 1 - ((idx - ST_SQ0) * SQ_STEPS + s);
        st = {o.srem, o.x[2*j +: 2]};
        trl = (SRW+2)'({o.root, 2'b01});
        qb = st >= trl;
        if (qb) st = st - trl;
        o.srem = st[SRW-1:0];
        o.root = {o.root[LW-2:0], qb};
      end
    end

    // normal component division by length
    if (idx >= ST_QD0 && idx < ST_QD0 + QD_STAGES) begin
      for (int s = 0; s < QD_STEPS; s++) begin
        kk = QW - 1 - ((idx - ST_QD0) * QD_STEPS + s);
        dv = NW'(o.root) << kk;
        for (int i = 0; i < 3; i++) begin
          if (o.qrem[i] >= dv) begin
            o.qrem[i] = o.qrem[i] - dv;
            o.q[i][kk] = 1'b1;
          end
        end
      end
    end
    return o;
  endfunction

endpackage

>>> rtl/sphere_triangle_contact.sv
// sphere_triangle_contact: top level, stream ports and the stage chain.
// Depends on stc_pkg and stc_stage.
//
// Usage: one beat on the slave side carries a triangle (three vertices and
// its unit normal) and a sphere (center, radius); one beat on the master
// side returns the contact flag, the unit push normal and the depth.
// Every input beat yields exactly one output beat, in order.
// The stage chain holds plane distance and projection, the edge cross
// products, an 18-step edge divider, a 30-step square root at three
// steps a stage and a 20-step normal divider at four steps a stage.
// Throughput is one beat per cycle while the receiver takes beats.
// When the receiver holds tready low with a beat waiting, the whole chain
// holds and s_axis_tready drops; no beat is lost or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
module sphere_triangle_contact (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // vertex_a, vertex_b, vertex_c, plane_normal, sphere_center, radius
  input  logic [stc_pkg::IN_TW-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // is_hit, push_normal, push_depth, zero fill
  output logic [stc_pkg::OUT_TW-1:0] m_axis_tdata
);
  import stc_pkg::*;

  item_t itm [N_STAGES+1];
  logic  vld [N_STAGES+1];
  logic  en;

  assign en            = !vld[N_STAGES] || m_axis_tready;
  assign s_axis_tready = en;
  assign vld[0]        = s_axis_tvalid;

  always_comb begin
    itm[0] = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      for (int v = 0; v < 3; v++) begin
        itm[0].vtx[v][i] = s_axis_tdata[v*FIELD_W + i*CW +: CW];
      end
      itm[0].n[i]   = s_axis_tdata[3*FIELD_W + i*CW +: CW];
      itm[0].ctr[i] = s_axis_tdata[4*FIELD_W + i*CW +: CW];
    end
    itm[0].rad = s_axis_tdata[5*FIELD_W +: RW];
  end

  for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
    stc_stage #(
      .STAGE(s)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (vld[s]),
      .in_item (itm[s]),
      .out_vld (vld[s+1]),
      .out_item(itm[s+1])
    );
  end

  assign m_axis_tvalid = vld[N_STAGES];
  assign m_axis_tdata  = {(OUT_TW-OUT_W)'(0), itm[N_STAGES].depth,
                          itm[N_STAGES].pnorm, itm[N_STAGES].hit};

endmodule

>>> rtl/stc_stage.sv
// stc_stage: one register stage of the contact pipeline, applying the
// datapath step selected by STAGE. Depends on stc_pkg.
module stc_stage #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  stc_pkg::item_t in_item,
  output logic           out_vld,
  output stc_pkg::item_t out_item
);
  import stc_pkg::*;

  item_t item_next;

  always_comb begin
    item_next = stc_step(in_item, STAGE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
